@@ src/pje_pkg.sv @@
// shared types, constants and the long-division step for the projection jacobian unit
// no dependencies
package pje_pkg;

	localparam int N_ENT     = 10;   // nonzero jacobian entries per point
	localparam int COORD_W   = 32;   // Q16.16 coordinate
	localparam int FOCAL_W   = 16;   // Q12.4 focal length
	localparam int RES_W     = 48;   // Q32.16 result
	localparam int NUM_W     = 96;   // scaled numerator
	localparam int DEN_W     = 63;   // ref_z squared magnitude
	localparam int REM_W     = 63;   // partial remainder, below den unless the entry overflows
	localparam int Q_W       = 48;   // quotient bits kept
	localparam int DIV_STEPS = 48;   // one quotient bit per stage
	localparam int SH_T      = 28;   // numerator scale for translation-only entries
	localparam int SH_R      = 12;   // numerator scale for the other entries
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_U = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_V = 2'd1;
	localparam logic [FOCAL_W-1:0]   FOCAL_RESET = 16'd8000;

	localparam logic [Q_W:0] POS_LIMIT = {2'b00, {(Q_W-1){1'b1}}};
	localparam logic [Q_W:0] NEG_LIMIT = {2'b01, {(Q_W-1){1'b0}}};

	// entry slots
	localparam int E_U_TX = 0;
	localparam int E_V_TY = 1;
	localparam int E_U_TZ = 2;
	localparam int E_V_TZ = 3;
	localparam int E_U_RX = 4;
	localparam int E_V_RX = 5;
	localparam int E_U_RY = 6;
	localparam int E_V_RY = 7;
	localparam int E_U_RZ = 8;
	localparam int E_V_RZ = 9;

	typedef struct packed {
		logic signed [COORD_W-1:0] prev_x;
		logic signed [COORD_W-1:0] prev_y;
		logic signed [COORD_W-1:0] prev_z;
		logic signed [COORD_W-1:0] ref_x;
		logic signed [COORD_W-1:0] ref_y;
		logic signed [COORD_W-1:0] ref_z;
	} in_word_t;

	typedef struct packed {
		logic signed [RES_W-1:0] j_u_tx;
		logic signed [RES_W-1:0] j_v_ty;
		logic signed [RES_W-1:0] j_u_tz;
		logic signed [RES_W-1:0] j_v_tz;
		logic signed [RES_W-1:0] j_u_rx;
		logic signed [RES_W-1:0] j_v_rx;
		logic signed [RES_W-1:0] j_u_ry;
		logic signed [RES_W-1:0] j_v_ry;
		logic signed [RES_W-1:0] j_u_rz;
		logic signed [RES_W-1:0] j_v_rz;
		logic                    depth_zero;
	} out_word_t;

	// front end to divider
	typedef struct packed {
		logic [N_ENT-1:0]            neg;
		logic [N_ENT-1:0][NUM_W-1:0] num;
		logic [DEN_W-1:0]            den;
		logic                        dz;
	} front_t;

	// one divider stage; lq holds remaining numerator bits with quotient bits shifted in
	typedef struct packed {
		logic [N_ENT-1:0]            neg;
		logic [N_ENT-1:0]            ovf;
		logic                        dz;
		logic [DEN_W-1:0]            den;
		logic [N_ENT-1:0][REM_W-1:0] rem;
		logic [N_ENT-1:0][Q_W-1:0]   lq;
	} dstage_t;

	function automatic dstage_t div_step(input dstage_t d);
		dstage_t r;
		logic [REM_W:0] t;
		r = d;
		for (int i = 0; i < N_ENT; i++) begin
			t = {d.rem[i], d.lq[i][Q_W-1]};
			if (t >= {1'b0, d.den}) begin
				r.rem[i] = REM_W'(t - {1'b0, d.den});
				r.lq[i]  = {d.lq[i][Q_W-2:0], 1'b1};
			end else begin
				r.rem[i] = t[REM_W-1:0];
				r.lq[i]  = {d.lq[i][Q_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

@@ src/pje_front.sv @@
// front end: sign split, products, signed sums and focal scaling, four stages
// depends on pje_pkg
module pje_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  pje_pkg::in_word_t            in_data,
	input  logic [pje_pkg::FOCAL_W-1:0]  focal_u,
	input  logic [pje_pkg::FOCAL_W-1:0]  focal_v,
	output logic                         out_valid,
	output pje_pkg::front_t              out_data
);

	typedef struct packed {
		logic px, py, pz, rx, ry, rz;
	} sign_t;

	function automatic logic [31:0] mag_of(input logic [31:0] v);
		logic [31:0] n;
		n = ~v + 32'd1;
		return v[31] ? n : v;
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// stage 1
	sign_t sg_s1;
	logic [31:0] mpx_s1, mpy_s1, mpz_s1, mrx_s1, mry_s1, mrz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sg_s1  <= '{in_data.prev_x[31], in_data.prev_y[31], in_data.prev_z[31],
			           in_data.ref_x[31], in_data.ref_y[31], in_data.ref_z[31]};
			mpx_s1 <= mag_of(in_data.prev_x);
			mpy_s1 <= mag_of(in_data.prev_y);
			mpz_s1 <= mag_of(in_data.prev_z);
			mrx_s1 <= mag_of(in_data.ref_x);
			mry_s1 <= mag_of(in_data.ref_y);
			mrz_s1 <= mag_of(in_data.ref_z);
		end
	end

	// stage 2: 32x32 and 32x16 products
	logic [63:0] den_p, zz_p, yy_p, xx_p, xy_p, yx_p, yz_p, xz_p;
	logic [47:0] fzu_p, fzv_p, fx_p, fy_p;

	assign den_p = mrz_s1 * mrz_s1;
	assign zz_p  = mpz_s1 * mrz_s1;
	assign yy_p  = mry_s1 * mpy_s1;
	assign xx_p  = mrx_s1 * mpx_s1;
	assign xy_p  = mrx_s1 * mpy_s1;
	assign yx_p  = mry_s1 * mpx_s1;
	assign yz_p  = mpy_s1 * mrz_s1;
	assign xz_p  = mpx_s1 * mrz_s1;
	assign fzu_p = mrz_s1 * focal_u;
	assign fzv_p = mrz_s1 * focal_v;
	assign fx_p  = mrx_s1 * focal_u;
	assign fy_p  = mry_s1 * focal_v;

	sign_t sg_s2;
	logic dz_s2;
	logic [pje_pkg::DEN_W-1:0] den_s2;
	logic [63:0] zz_s2, yy_s2, xx_s2, xy_s2, yx_s2, yz_s2, xz_s2;
	logic [47:0] fzu_s2, fzv_s2, fx_s2, fy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sg_s2  <= sg_s1;
			dz_s2  <= (mrz_s1 == 32'd0);
			den_s2 <= den_p[pje_pkg::DEN_W-1:0];
			zz_s2  <= zz_p;
			yy_s2  <= yy_p;
			xx_s2  <= xx_p;
			xy_s2  <= xy_p;
			yx_s2  <= yx_p;
			yz_s2  <= yz_p;
			xz_s2  <= xz_p;
			fzu_s2 <= fzu_p;
			fzv_s2 <= fzv_p;
			fx_s2  <= fx_p;
			fy_s2  <= fy_p;
		end
	end

	// stage 3: prev_z*ref_z plus ref_y*prev_y and ref_x*prev_x, sign-magnitude
	logic       sz, sa1, sa2, n1, n2;
	logic [64:0] m1, m2;

	always_comb begin
		sz  = sg_s2.pz ^ sg_s2.rz;
		sa1 = sg_s2.ry ^ sg_s2.py;
		sa2 = sg_s2.rx ^ sg_s2.px;
		if (sz == sa1) begin
			n1 = sz;
			m1 = {1'b0, zz_s2} + {1'b0, yy_s2};
		end else if (zz_s2 >= yy_s2) begin
			n1 = sz;
			m1 = {1'b0, zz_s2 - yy_s2};
		end else begin
			n1 = sa1;
			m1 = {1'b0, yy_s2 - zz_s2};
		end
		if (sz == sa2) begin
			n2 = sz;
			m2 = {1'b0, zz_s2} + {1'b0, xx_s2};
		end else if (zz_s2 >= xx_s2) begin
			n2 = sz;
			m2 = {1'b0, zz_s2 - xx_s2};
		end else begin
			n2 = sa2;
			m2 = {1'b0, xx_s2 - zz_s2};
		end
	end

	sign_t sg_s3;
	logic dz_s3, n1_s3, n2_s3;
	logic [pje_pkg::DEN_W-1:0] den_s3;
	logic [64:0] m1_s3, m2_s3;
	logic [63:0] xy_s3, yx_s3, yz_s3, xz_s3;
	logic [47:0] fzu_s3, fzv_s3, fx_s3, fy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sg_s3  <= sg_s2;
			dz_s3  <= dz_s2;
			den_s3 <= den_s2;
			n1_s3  <= n1;
			n2_s3  <= n2;
			m1_s3  <= m1;
			m2_s3  <= m2;
			xy_s3  <= xy_s2;
			yx_s3  <= yx_s2;
			yz_s3  <= yz_s2;
			xz_s3  <= xz_s2;
			fzu_s3 <= fzu_s2;
			fzv_s3 <= fzv_s2;
			fx_s3  <= fx_s2;
			fy_s3  <= fy_s2;
		end
	end

	// stage 4: focal scaling of the rotation terms, numerator alignment
	logic [80:0] q_urx, q_vrx, q_ury, q_vry, q_urz, q_vrz;
	pje_pkg::front_t f_c;

	assign q_urx = xy_s3 * focal_u;
	assign q_vrx = m1_s3 * focal_v;
	assign q_ury = m2_s3 * focal_u;
	assign q_vry = yx_s3 * focal_v;
	assign q_urz = yz_s3 * focal_u;
	assign q_vrz = xz_s3 * focal_v;

	always_comb begin
		f_c.den = den_s3;
		f_c.dz  = dz_s3;
		f_c.neg[pje_pkg::E_U_TX] = sg_s3.rz;
		f_c.neg[pje_pkg::E_V_TY] = sg_s3.rz;
		f_c.neg[pje_pkg::E_U_TZ] = ~sg_s3.rx;
		f_c.neg[pje_pkg::E_V_TZ] = ~sg_s3.ry;
		f_c.neg[pje_pkg::E_U_RX] = ~(sg_s3.rx ^ sg_s3.py);
		f_c.neg[pje_pkg::E_V_RX] = ~n1_s3;
		f_c.neg[pje_pkg::E_U_RY] = n2_s3;
		f_c.neg[pje_pkg::E_V_RY] = sg_s3.ry ^ sg_s3.px;
		f_c.neg[pje_pkg::E_U_RZ] = ~(sg_s3.py ^ sg_s3.rz);
		f_c.neg[pje_pkg::E_V_RZ] = sg_s3.px ^ sg_s3.rz;
		f_c.num[pje_pkg::E_U_TX] = pje_pkg::NUM_W'({fzu_s3, {pje_pkg::SH_T{1'b0}}});
		f_c.num[pje_pkg::E_V_TY] = pje_pkg::NUM_W'({fzv_s3, {pje_pkg::SH_T{1'b0}}});
		f_c.num[pje_pkg::E_U_TZ] = pje_pkg::NUM_W'({fx_s3, {pje_pkg::SH_T{1'b0}}});
		f_c.num[pje_pkg::E_V_TZ] = pje_pkg::NUM_W'({fy_s3, {pje_pkg::SH_T{1'b0}}});
		f_c.num[pje_pkg::E_U_RX] = pje_pkg::NUM_W'({q_urx, {pje_pkg::SH_R{1'b0}}});
		f_c.num[pje_pkg::E_V_RX] = pje_pkg::NUM_W'({q_vrx, {pje_pkg::SH_R{1'b0}}});
		f_c.num[pje_pkg::E_U_RY] = pje_pkg::NUM_W'({q_ury, {pje_pkg::SH_R{1'b0}}});
		f_c.num[pje_pkg::E_V_RY] = pje_pkg::NUM_W'({q_vry, {pje_pkg::SH_R{1'b0}}});
		f_c.num[pje_pkg::E_U_RZ] = pje_pkg::NUM_W'({q_urz, {pje_pkg::SH_R{1'b0}}});
		f_c.num[pje_pkg::E_V_RZ] = pje_pkg::NUM_W'({q_vrz, {pje_pkg::SH_R{1'b0}}});
	end

	pje_pkg::front_t f_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s4 <= f_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = f_s4;

endmodule

@@ src/pje_div.sv @@
// pipelined restoring divider, ten lanes sharing one denominator, one quotient bit per stage
// depends on pje_pkg
module pje_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  pje_pkg::front_t   in_data,
	output logic              out_valid,
	output pje_pkg::dstage_t  out_data
);

	pje_pkg::dstage_t stg_s [0:pje_pkg::DIV_STEPS];
	logic [pje_pkg::DIV_STEPS:0] vld_s;
	pje_pkg::dstage_t init_c;

	// quotient of 2^48 or more saturates whatever the sign
	always_comb begin
		init_c.neg = in_data.neg;
		init_c.dz  = in_data.dz;
		init_c.den = in_data.den;
		for (int i = 0; i < pje_pkg::N_ENT; i++) begin
			init_c.rem[i] = pje_pkg::REM_W'(in_data.num[i][pje_pkg::NUM_W-1:pje_pkg::Q_W]);
			init_c.ovf[i] = pje_pkg::REM_W'(in_data.num[i][pje_pkg::NUM_W-1:pje_pkg::Q_W])
				>= in_data.den;
			init_c.lq[i]  = in_data.num[i][pje_pkg::Q_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= init_c;
		end
	end

	for (genvar k = 1; k <= pje_pkg::DIV_STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k] <= pje_pkg::div_step(stg_s[k-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[pje_pkg::DIV_STEPS-1:0], in_valid};
		end
	end

	assign out_valid = vld_s[pje_pkg::DIV_STEPS];
	assign out_data  = stg_s[pje_pkg::DIV_STEPS];

endmodule

@@ src/pje_finish.sv @@
// rounding stage, then saturation, sign and zero-depth forcing of the ten entries
// depends on pje_pkg
module pje_finish (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  pje_pkg::dstage_t   in_data,
	output logic               out_valid,
	output pje_pkg::out_word_t out_data
);

	logic [pje_pkg::N_ENT-1:0][pje_pkg::Q_W:0] qr_c;
	logic [pje_pkg::N_ENT-1:0][pje_pkg::Q_W:0] qr_s54;
	logic [pje_pkg::N_ENT-1:0] neg_s54, ovf_s54;
	logic dz_s54, vld_s54;

	// round half away from zero on the magnitude
	always_comb begin
		for (int i = 0; i < pje_pkg::N_ENT; i++) begin
			qr_c[i] = {1'b0, in_data.lq[i]}
				+ (pje_pkg::Q_W+1)'({in_data.rem[i], 1'b0} >= {1'b0, in_data.den});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s54  <= qr_c;
			neg_s54 <= in_data.neg;
			ovf_s54 <= in_data.ovf;
			dz_s54  <= in_data.dz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s54 <= 1'b0;
		end else if (en) begin
			vld_s54 <= in_valid;
		end
	end

	logic [pje_pkg::N_ENT-1:0][pje_pkg::RES_W-1:0] ent;
	logic [pje_pkg::Q_W:0] lim, mag;

	always_comb begin
		lim = '0;
		mag = '0;
		for (int i = 0; i < pje_pkg::N_ENT; i++) begin
			lim = neg_s54[i] ? pje_pkg::NEG_LIMIT : pje_pkg::POS_LIMIT;
			mag = (ovf_s54[i] || qr_s54[i] > lim) ? lim : qr_s54[i];
			if (dz_s54) begin
				ent[i] = '0;
			end else if (neg_s54[i]) begin
				ent[i] = pje_pkg::RES_W'(~mag[pje_pkg::RES_W-1:0] + 1'b1);
			end else begin
				ent[i] = mag[pje_pkg::RES_W-1:0];
			end
		end
	end

	always_comb begin
		out_data.j_u_tx     = ent[pje_pkg::E_U_TX];
		out_data.j_v_ty     = ent[pje_pkg::E_V_TY];
		out_data.j_u_tz     = ent[pje_pkg::E_U_TZ];
		out_data.j_v_tz     = ent[pje_pkg::E_V_TZ];
		out_data.j_u_rx     = ent[pje_pkg::E_U_RX];
		out_data.j_v_rx     = ent[pje_pkg::E_V_RX];
		out_data.j_u_ry     = ent[pje_pkg::E_U_RY];
		out_data.j_v_ry     = ent[pje_pkg::E_V_RY];
		out_data.j_u_rz     = ent[pje_pkg::E_U_RZ];
		out_data.j_v_rz     = ent[pje_pkg::E_V_RZ];
		out_data.depth_zero = dz_s54;
	end

	assign out_valid = vld_s54;

endmodule

@@ src/projection_jacobian_se3_unit.sv @@
// top level: pinhole projection jacobian wrt an se(3) twist, output register and skid
// depends on pje_pkg, pje_front, pje_div, pje_finish
//
//  channel  handshake              payload
//  in       in_valid / in_ready    in_data    (pje_pkg::in_word_t, one point)
//  out      out_valid / out_ready  out_data   (pje_pkg::out_word_t, ten entries + flag)
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (focal_u = 0, focal_v = 1)
//
// one word accepted per cycle while in_ready is high, one result word per word, in order
// pipe: 4 front stages, divider entry plus 48 one-bit stages, rounding, output reg
// the 48-stage divider sets the depth; every stage advances together
// a skid register holds one result while out_ready is low; in_ready is a registered
// not-full of that skid, so the pipe stalls as a whole and nothing is lost or repeated
// reset clears valid bits and sets both focal lengths to 500.0 pixels; cfg_ready is always high
module projection_jacobian_se3_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pje_pkg::in_word_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pje_pkg::out_word_t               out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pje_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pje_pkg::FOCAL_W-1:0]      cfg_data
);

	// focal length registers
	logic [pje_pkg::FOCAL_W-1:0] focal_u_q, focal_v_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_u_q <= pje_pkg::FOCAL_RESET;
			focal_v_q <= pje_pkg::FOCAL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pje_pkg::REG_FOCAL_U: focal_u_q <= cfg_data;
				pje_pkg::REG_FOCAL_V: focal_v_q <= cfg_data;
				default: ;    // unknown index, write dropped
			endcase
		end
	end

	// whole-pipe advance while the skid is empty
	logic adv;
	logic skid_vld_q, out_vld_q;
	pje_pkg::out_word_t skid_q, out_q;

	assign adv      = ~skid_vld_q;
	assign in_ready = adv;

	logic               fr_vld, dv_vld, fin_vld;
	pje_pkg::front_t    fr_data;
	pje_pkg::dstage_t   dv_data;
	pje_pkg::out_word_t fin_data;

	pje_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.focal_u   (focal_u_q),
		.focal_v   (focal_v_q),
		.out_valid (fr_vld),
		.out_data  (fr_data)
	);

	pje_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (fr_vld),
		.in_data   (fr_data),
		.out_valid (dv_vld),
		.out_data  (dv_data)
	);

	pje_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (dv_vld),
		.in_data   (dv_data),
		.out_valid (fin_vld),
		.out_data  (fin_data)
	);

	// result leaving the pipe this cycle
	logic push;
	assign push = adv & fin_vld;

	// output register with one-word skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			out_q <= skid_vld_q ? skid_q : fin_data;
		end else if (push) begin
			skid_q <= fin_data;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// skid only ever fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a word while the output register is empty");

	// a full skid waits while the consumer stalls
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !out_ready |=> skid_vld_q && out_vld_q)
		else $error("skid word dropped during a stall");

	// zero depth forces every entry to zero
	a_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.depth_zero |->
			out_q.j_u_tx == '0 && out_q.j_v_ty == '0 && out_q.j_u_tz == '0 &&
			out_q.j_v_tz == '0 && out_q.j_u_rx == '0 && out_q.j_v_rx == '0 &&
			out_q.j_u_ry == '0 && out_q.j_v_ry == '0 && out_q.j_u_rz == '0 &&
			out_q.j_v_rz == '0)
		else $error("nonzero entry with depth_zero set");

	// a focal_u write lands in the register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == pje_pkg::REG_FOCAL_U |=> focal_u_q == $past(cfg_data))
		else $error("focal_u write lost");

endmodule

@@ test/tb_top.sv @@
// testbench for projection_jacobian_se3_unit: random and directed points against a scoreboard
// depends on pje_pkg and the projection_jacobian_se3_unit rtl
module tb_top;

	// register indexes outside the map, writes there must be dropped
	localparam logic [pje_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [pje_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int DRAIN_CYCLES = 70;   // a bit over the pipe depth
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off

	// jacobian predictor plus queue of pending result words
	class jacobian_board;
		logic [pje_pkg::FOCAL_W-1:0] fu, fv;
		pje_pkg::out_word_t pending_words[$];
		int errors;

		function new();
			fu = pje_pkg::FOCAL_RESET;
			fv = pje_pkg::FOCAL_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [pje_pkg::CFG_IDX_W-1:0] idx,
				logic [pje_pkg::FOCAL_W-1:0] val);
			if (idx == pje_pkg::REG_FOCAL_U)
				fu = val;
			else if (idx == pje_pkg::REG_FOCAL_V)
				fv = val;
		endfunction

		// sign / magnitude of a Q16.16 coordinate
		function void split_coord(logic [31:0] v, output bit sgn, output logic [63:0] mag);
			sgn = v[31];
			mag = sgn ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
		endfunction

		function void add_sm(bit sa, logic [63:0] ma, bit sb, logic [63:0] mb,
				output bit so, output logic [63:0] mo);
			if (sa == sb) begin
				so = sa;
				mo = ma + mb;
			end else if (ma >= mb) begin
				so = sa;
				mo = ma - mb;
			end else begin
				so = sb;
				mo = mb - ma;
			end
		endfunction

		// ((mag*k) << sh) / den, rounded half away from zero, saturated to 48 bits
		function logic [pje_pkg::RES_W-1:0] scaled_quot(bit neg, logic [63:0] mag,
				logic [31:0] k, int sh, logic [63:0] den);
			logic [191:0] num, q, r, d, lim;
			num = {128'b0, mag} * {160'b0, k};
			num = num << sh;
			d = {128'b0, den};
			q = num / d;
			r = num % d;
			if (r >= d - r)
				q = q + 1;
			lim = neg ? 192'h8000_0000_0000 : 192'h7FFF_FFFF_FFFF;
			if (q > lim)
				q = lim;
			return neg ? pje_pkg::RES_W'(-q[pje_pkg::RES_W-1:0]) : q[pje_pkg::RES_W-1:0];
		endfunction

		function pje_pkg::out_word_t predict(pje_pkg::in_word_t p);
			pje_pkg::out_word_t e;
			bit spx, spy, spz, srx, sry, srz, s1, s2;
			logic [63:0] mpx, mpy, mpz, mrx, mry, mrz, m1, m2, den;
			split_coord(p.prev_x, spx, mpx);
			split_coord(p.prev_y, spy, mpy);
			split_coord(p.prev_z, spz, mpz);
			split_coord(p.ref_x, srx, mrx);
			split_coord(p.ref_y, sry, mry);
			split_coord(p.ref_z, srz, mrz);
			e = '0;
			if (mrz == 0) begin
				e.depth_zero = 1'b1;
				return e;
			end
			den = mrz * mrz;
			add_sm(spz ^ srz, mpz * mrz, sry ^ spy, mry * mpy, s1, m1);
			add_sm(spz ^ srz, mpz * mrz, srx ^ spx, mrx * mpx, s2, m2);
			e.j_u_tx = scaled_quot(srz, mrz * fu, 1, pje_pkg::SH_T, den);
			e.j_v_ty = scaled_quot(srz, mrz * fv, 1, pje_pkg::SH_T, den);
			e.j_u_tz = scaled_quot(~srx, mrx * fu, 1, pje_pkg::SH_T, den);
			e.j_v_tz = scaled_quot(~sry, mry * fv, 1, pje_pkg::SH_T, den);
			e.j_u_rx = scaled_quot(~(srx ^ spy), mrx * mpy, fu, pje_pkg::SH_R, den);
			e.j_v_rx = scaled_quot(~s1, m1, fv, pje_pkg::SH_R, den);
			e.j_u_ry = scaled_quot(s2, m2, fu, pje_pkg::SH_R, den);
			e.j_v_ry = scaled_quot(sry ^ spx, mry * mpx, fv, pje_pkg::SH_R, den);
			e.j_u_rz = scaled_quot(~(spy ^ srz), mpy * mrz, fu, pje_pkg::SH_R, den);
			e.j_v_rz = scaled_quot(spx ^ srz, mpx * mrz, fv, pje_pkg::SH_R, den);
			return e;
		endfunction

		function void note_point(pje_pkg::in_word_t p);
			pending_words.insert(pending_words.size(), predict(p));
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task cmp(string name, logic [pje_pkg::RES_W-1:0] got,
				logic [pje_pkg::RES_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check_word(pje_pkg::out_word_t got);
			pje_pkg::out_word_t w;
			if (pending_words.size() == 0) begin
				report("result word with nothing pending");
				return;
			end
			w = pending_words.pop_front();
			cmp("j_u_tx", got.j_u_tx, w.j_u_tx);
			cmp("j_v_ty", got.j_v_ty, w.j_v_ty);
			cmp("j_u_tz", got.j_u_tz, w.j_u_tz);
			cmp("j_v_tz", got.j_v_tz, w.j_v_tz);
			cmp("j_u_rx", got.j_u_rx, w.j_u_rx);
			cmp("j_v_rx", got.j_v_rx, w.j_v_rx);
			cmp("j_u_ry", got.j_u_ry, w.j_u_ry);
			cmp("j_v_ry", got.j_v_ry, w.j_v_ry);
			cmp("j_u_rz", got.j_u_rz, w.j_u_rz);
			cmp("j_v_rz", got.j_v_rz, w.j_v_rz);
			if (got.depth_zero !== w.depth_zero)
				report($sformatf("depth_zero got %b want %b", got.depth_zero, w.depth_zero));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pje_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pje_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pje_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pje_pkg::FOCAL_W-1:0] cfg_data = '0;

	// long hold-off request from the stimulus thread to the receiver
	bit hold_req = 1'b0;

	jacobian_board board = new();

	projection_jacobian_se3_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// monitors: sample pre-edge values, so ordering against the rtl does not matter
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_point(in_data);
		if (arst_n && out_valid && out_ready)
			board.check_word(out_data);
		if (arst_n && cfg_valid && cfg_ready)
			board.write_reg(cfg_index, cfg_data);
	end

	// receiver: random stall pattern that changes character every so often,
	// plus an occasional long hold-off counted here
	int rx_mode = 0;
	int rx_left = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 120);
		end
		rx_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else case (rx_mode)
			0: out_ready <= 1'b1;                      // no stalls
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 1) != 0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// random coordinate: mostly plausible scene values, sometimes extremes or raw noise
	function automatic logic [31:0] rand_coord(bit depth);
		int pick;
		logic [31:0] v;
		pick = $urandom_range(0, 19);
		if (pick < 13) begin
			v = depth ? $urandom_range(32768, 40 << 16) : $urandom_range(0, 20 << 16);
			if ($urandom_range(0, depth ? 9 : 1) == 0)
				v = -v;
		end else if (pick < 15)
			v = $urandom_range(0, 15);
		else if (pick < 16)
			v = -$urandom_range(1, 15);
		else if (pick < 17) begin
			case ($urandom_range(0, 3))
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'hFFFF_FFFF;
				default: v = 32'h0;
			endcase
		end else
			v = $urandom;
		return v;
	endfunction

	// offer one word and wait for it to be taken; valid stays up for back-to-back words
	task put_point(pje_pkg::in_word_t p);
		in_valid <= 1'b1;
		in_data <= p;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task idle_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task send_random(int n);
		pje_pkg::in_word_t p;
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && n > 0) begin
				p.prev_x = rand_coord(0);
				p.prev_y = rand_coord(0);
				p.prev_z = rand_coord(1);
				p.ref_x = rand_coord(0);
				p.ref_y = rand_coord(0);
				p.ref_z = ($urandom_range(0, 29) == 0) ? 32'h0 : rand_coord(1);
				put_point(p);
				burst--;
				n--;
			end
			if ($urandom_range(0, 2) != 0)
				idle_sender($urandom_range(1, 12));
		end
		in_valid <= 1'b0;
	endtask

	// wait for the pipe to empty; extra cycles before any register write
	task drain;
		in_valid <= 1'b0;
		while (board.pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_cfg(logic [pje_pkg::CFG_IDX_W-1:0] idx, logic [pje_pkg::FOCAL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task set_focals(logic [pje_pkg::FOCAL_W-1:0] u, logic [pje_pkg::FOCAL_W-1:0] v);
		write_cfg(pje_pkg::REG_FOCAL_U, u);
		write_cfg(pje_pkg::REG_FOCAL_V, v);
	endtask

	task send_directed;
		pje_pkg::in_word_t p;
		// typical point, 5 m in front
		p = '{32'h0001_0000, 32'hFFFF_8000, 32'h0004_0000,
			32'h0001_2000, 32'hFFFF_6000, 32'h0005_0000};
		put_point(p);
		// zero refined depth, all entries forced to zero
		p.ref_z = 32'h0;
		put_point(p);
		p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0};
		put_point(p);
		// tiny depth, most entries saturate
		p.ref_z = 32'h0000_0001;
		put_point(p);
		p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF};
		put_point(p);
		p.ref_z = 32'h8000_0000;
		put_point(p);
		p.ref_z = 32'h7FFF_FFFF;
		put_point(p);
		p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		put_point(p);
		p = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000};
		put_point(p);
		// negative depth, point behind the camera
		p = '{32'hFFFE_0000, 32'h0003_0000, 32'hFFFD_0000,
			32'h0002_8000, 32'hFFFC_0000, 32'hFFFA_0000};
		put_point(p);
		// cancellation inside the rotation sums
		p = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000};
		put_point(p);
		p = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003};
		put_point(p);
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset focal lengths first
		send_directed();
		send_random(150);

		// sender pauses until everything has come back, then a long receiver hold-off
		drain();
		set_focals(16'd1, 16'd65535);
		hold_req = 1'b1;
		send_random(150);
		send_directed();

		drain();
		set_focals(16'd65535, 16'd1);
		write_cfg(REG_SPARE_2, 16'h1234);
		write_cfg(REG_SPARE_3, 16'hFFFF);
		send_directed();
		send_random(150);

		// zero focal lengths scale their entries to zero
		drain();
		set_focals(16'd0, 16'd0);
		send_random(60);

		drain();
		set_focals(16'hFFFF, 16'hFFFF);
		send_random(120);

		drain();
		set_focals(16'h0001, 16'h0001);
		send_random(100);

		drain();
		set_focals(pje_pkg::FOCAL_W'($urandom_range(1, 65535)),
			pje_pkg::FOCAL_W'($urandom_range(1, 65535)));
		hold_req = 1'b1;
		send_random(150);

		drain();
		set_focals(16'd8000, 16'd8000);
		send_random(120);

		drain();
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// stalls leave this far beyond the slowest correct run
	initial begin
		#(20 * 2000000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
